[hw/rtl/pbn_pkg.sv]
// Shared types and constants of the palette blend nearest-colour block.
package pbn_pkg;

   localparam int ColorBits             = 8;
   localparam int IndexBits             = 8;
   localparam int PercentBits           = 7;
   localparam int PercentScale          = 100;
   localparam int PaletteEntriesDefault = 256;
   localparam int WeightFracDefault     = 12;
   localparam int ReqDataBits           = 48;

   localparam logic [PercentBits-1:0] PercentReset = 7'd66;
   localparam logic [PercentBits-1:0] MaxPercent   = 7'd99;

   localparam logic OpLoad  = 1'b0;
   localparam logic OpQuery = 1'b1;

   typedef struct packed {
      logic [ColorBits-1:0] blue;
      logic [ColorBits-1:0] green;
      logic [ColorBits-1:0] red;
   } color_type;

   typedef struct packed {
      logic prod_en;
      logic sum_en;
   } mix_ctl_type;

   typedef struct packed {
      logic                 valid;
      logic                 first;
      logic                 last;
      logic [IndexBits-1:0] index;
   } score_ctl_type;

endpackage

[hw/rtl/pbn_palette_ram.sv]
// Palette memory: one write port, one read port with registered read data.
module pbn_palette_ram import pbn_pkg::*; #(
   parameter int Entries = PaletteEntriesDefault,
   parameter int AddrW   = $clog2(PaletteEntriesDefault)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  color_type        wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output color_type        rd_data
);

   color_type mem [Entries];
   color_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/pbn_mixer.sv]
// Blend weights from the opacity percent and the weighted foreground/background mix.
module pbn_mixer import pbn_pkg::*; #(
   parameter int WeightFrac = WeightFracDefault,
   parameter int MixW       = WeightFracDefault + 8
) (
   input  logic                      clock,
   input  logic [PercentBits-1:0]    percent,
   input  mix_ctl_type               ctl,
   input  color_type                 fore_color,
   input  color_type                 back_color,
   output logic [2:0][MixW-1:0]      mix
);

   localparam int WeightW    = WeightFrac + 1;
   localparam int PctW       = PercentBits + WeightFrac;
   localparam int RecipShift = WeightFrac + 14;
   localparam int RecW       = WeightFrac + 8;
   localparam int ProdW      = PctW + RecW;
   localparam int TermW      = ColorBits + WeightW;
   localparam logic [RecW-1:0] Recip =
      RecW'(((64'd1 << RecipShift) + 64'(PercentScale) - 64'd1) / 64'(PercentScale));
   localparam logic [WeightW-1:0] WeightOne = WeightW'(1) << WeightFrac;

   logic [PercentBits-1:0] pct_sat;
   logic [PctW-1:0]        pct_scaled;
   logic [ProdW-1:0]       w1_prod;
   logic [WeightW-1:0]     w1_in, w1_ff, w2;
   logic [2:0][TermW-1:0]  fp_ff, bp_ff;
   logic [2:0][MixW-1:0]   mix_ff;

   // Divide by the percent scale through a reciprocal; exact for every legal percent
   assign pct_sat    = (percent > MaxPercent) ? MaxPercent : percent;
   assign pct_scaled = {pct_sat, {WeightFrac{1'b0}}};
   assign w1_prod    = ProdW'(pct_scaled) * ProdW'(Recip);
   assign w1_in      = WeightW'(w1_prod >> RecipShift);
   assign w2         = WeightOne - w1_ff;

   always_ff @(posedge clock) begin
      w1_ff <= w1_in;
      if (ctl.prod_en) begin
         fp_ff[0] <= TermW'(fore_color.red)   * TermW'(w1_ff);
         fp_ff[1] <= TermW'(fore_color.green) * TermW'(w1_ff);
         fp_ff[2] <= TermW'(fore_color.blue)  * TermW'(w1_ff);
         bp_ff[0] <= TermW'(back_color.red)   * TermW'(w2);
         bp_ff[1] <= TermW'(back_color.green) * TermW'(w2);
         bp_ff[2] <= TermW'(back_color.blue)  * TermW'(w2);
      end
      if (ctl.sum_en) begin
         for (int i = 0; i < 3; i++) begin
            mix_ff[i] <= MixW'(fp_ff[i]) + MixW'(bp_ff[i]);
         end
      end
   end

   assign mix = mix_ff;

endmodule

[hw/rtl/pbn_scorer.sv]
// Scores each palette entry against the mix and keeps the lowest, ties to the first seen.
module pbn_scorer import pbn_pkg::*; #(
   parameter int WeightFrac = WeightFracDefault,
   parameter int MixW       = WeightFracDefault + 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  score_ctl_type         ctl,
   input  color_type             color,
   input  logic [2:0][MixW-1:0]  mix,
   output logic                  done,
   output logic [IndexBits-1:0]  best_index
);

   localparam int SqW   = 2 * ColorBits;
   localparam int DotW  = ColorBits + MixW;
   localparam int SqSumW  = SqW + 2;
   localparam int DotSumW = DotW + 2;
   localparam int ShW   = SqSumW + WeightFrac - 1;
   localparam int ErrW  = WeightFrac + 19;

   score_ctl_type         prod_ctl_ff, err_ctl_ff;
   logic [2:0][SqW-1:0]   sq_ff;
   logic [2:0][DotW-1:0]  dot_ff;
   logic [SqSumW-1:0]     sq_sum;
   logic [DotSumW-1:0]    dot_sum;
   logic [ShW-1:0]        sq_sh;
   logic signed [ErrW-1:0] err_in, err_ff, best_ff, best_in;
   logic [IndexBits-1:0]  best_idx_ff, best_idx_in;
   logic                  done_ff;
   logic                  take;

   always_ff @(posedge clock) begin
      sq_ff[0]  <= SqW'(color.red)   * SqW'(color.red);
      sq_ff[1]  <= SqW'(color.green) * SqW'(color.green);
      sq_ff[2]  <= SqW'(color.blue)  * SqW'(color.blue);
      dot_ff[0] <= DotW'(color.red)   * DotW'(mix[0]);
      dot_ff[1] <= DotW'(color.green) * DotW'(mix[1]);
      dot_ff[2] <= DotW'(color.blue)  * DotW'(mix[2]);
   end

   assign sq_sum  = SqSumW'(sq_ff[0]) + SqSumW'(sq_ff[1]) + SqSumW'(sq_ff[2]);
   assign dot_sum = DotSumW'(dot_ff[0]) + DotSumW'(dot_ff[1]) + DotSumW'(dot_ff[2]);
   assign sq_sh   = {sq_sum, {(WeightFrac-1){1'b0}}};
   assign err_in  = $signed(ErrW'(sq_sh)) - $signed(ErrW'(dot_sum));

   always_ff @(posedge clock) begin
      err_ff <= err_in;
   end

   // Strict less-than: scanning runs downwards, so ties stay with the higher index
   assign take        = err_ctl_ff.valid && (err_ctl_ff.first || (err_ff < best_ff));
   assign best_in     = take ? err_ff : best_ff;
   assign best_idx_in = take ? err_ctl_ff.index : best_idx_ff;

   always_ff @(posedge clock) begin
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ctl_ff <= '0;
         err_ctl_ff  <= '0;
         done_ff     <= 1'b0;
      end else begin
         prod_ctl_ff <= ctl;
         err_ctl_ff  <= prod_ctl_ff;
         done_ff     <= err_ctl_ff.valid && err_ctl_ff.last;
      end
   end

   assign done       = done_ff;
   assign best_index = best_idx_ff;

endmodule

[hw/rtl/palette_blend_nearest_color.sv]
// Palette blend nearest-colour top level: item sequencer, palette memory, mixer, scorer.
//
// A load item (req_tuser low) writes one palette entry and is taken in the idle state. A
// query item (req_tuser high) blends the foreground and background entries with the
// opacity held in the configuration register and returns the index of the nearest palette
// entry. A query occupies the block from its acceptance to the next free input slot: two
// read states fetch the two colours and two mix states form the mix, then every entry is
// read once through the palette memory's single read port, one per cycle, the scoring
// pipeline drains and a done state moves the index to the output register. While an
// earlier result still waits untaken, the finished query holds the input off. Items are
// taken one at a time; a finished index waits in the output register while the next item
// is accepted. Every palette entry must be loaded before a query reads it.
module palette_blend_nearest_color import pbn_pkg::*; #(
   parameter int PALETTE_ENTRIES      = PaletteEntriesDefault,
   parameter int WEIGHT_FRACTION_BITS = WeightFracDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // entry_index, red, green, blue, fore_index, back_index (8 bits each, from bit 0)
   input  logic [ReqDataBits-1:0] req_tdata,
   // operation
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // blended_index
   output logic [IndexBits-1:0]   rsp_tdata,
   input  logic                   csr_we,
   input  logic [PercentBits-1:0] csr_wdata
);

   localparam int AddrW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam int MixW  = WEIGHT_FRACTION_BITS + 8;
   localparam logic [IndexBits:0] EntryLimit = (IndexBits+1)'(PALETTE_ENTRIES);
   localparam logic [AddrW-1:0]   LastAddr   = AddrW'(PALETTE_ENTRIES - 1);

   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StRdF   = 3'd1;
   localparam logic [2:0] StRdB   = 3'd2;
   localparam logic [2:0] StMixA  = 3'd3;
   localparam logic [2:0] StMixB  = 3'd4;
   localparam logic [2:0] StScan  = 3'd5;
   localparam logic [2:0] StDrain = 3'd6;
   localparam logic [2:0] StDone  = 3'd7;

   logic [2:0]             state_ff, state_in;
   logic [PercentBits-1:0] pct_ff;
   logic [IndexBits-1:0]   fore_ff, back_ff;
   logic                   fore_oob_ff, back_oob_ff;
   logic [AddrW-1:0]       cnt_ff, cnt_in;
   color_type              fore_color_ff, back_color;
   score_ctl_type          issue_ctl_ff, issue_ctl_in;
   logic                   rsp_valid_ff;
   logic [IndexBits-1:0]   rsp_data_ff;

   logic [IndexBits-1:0]   entry_index, fore_index, back_index;
   color_type              load_color, rd_data;
   logic                   req_fire, load_fire, query_fire;
   logic                   load_in_range;
   logic                   rd_en;
   logic [AddrW-1:0]       rd_addr;
   mix_ctl_type            mix_ctl;
   logic [2:0][MixW-1:0]   mix;
   logic                   score_done;
   logic [IndexBits-1:0]   best_index;
   logic                   rsp_free;

   assign entry_index      = req_tdata[7:0];
   assign load_color.red   = req_tdata[15:8];
   assign load_color.green = req_tdata[23:16];
   assign load_color.blue  = req_tdata[31:24];
   assign fore_index       = req_tdata[39:32];
   assign back_index       = req_tdata[47:40];

   assign req_tready    = (state_ff == StIdle);
   assign req_fire      = req_tvalid && req_tready;
   assign load_fire     = req_fire && (req_tuser == OpLoad);
   assign query_fire    = req_fire && (req_tuser == OpQuery);
   assign load_in_range = ({1'b0, entry_index} < EntryLimit);
   assign rsp_free      = !rsp_valid_ff || rsp_tready;

   // Loads and scans never overlap: the sequencer takes no item while a query runs
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = cnt_ff;
      case (state_ff)
         StRdF: begin
            rd_en   = 1'b1;
            rd_addr = fore_ff[AddrW-1:0];
         end
         StRdB: begin
            rd_en   = 1'b1;
            rd_addr = back_ff[AddrW-1:0];
         end
         StScan: begin
            rd_en   = 1'b1;
            rd_addr = cnt_ff;
         end
         default: begin
            rd_en   = 1'b0;
            rd_addr = cnt_ff;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      issue_ctl_in = '0;
      mix_ctl      = '0;
      case (state_ff)
         StIdle: begin
            if (query_fire) begin
               state_in = StRdF;
            end
         end
         StRdF:  state_in = StRdB;
         StRdB:  state_in = StMixA;
         StMixA: begin
            mix_ctl.prod_en = 1'b1;
            state_in        = StMixB;
         end
         StMixB: begin
            mix_ctl.sum_en = 1'b1;
            cnt_in         = LastAddr;
            state_in       = StScan;
         end
         StScan: begin
            issue_ctl_in.valid = 1'b1;
            issue_ctl_in.first = (cnt_ff == LastAddr);
            issue_ctl_in.last  = (cnt_ff == '0);
            issue_ctl_in.index = IndexBits'(cnt_ff);
            cnt_in             = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = StDrain;
            end
         end
         StDrain: begin
            if (score_done) begin
               state_in = StDone;
            end
         end
         StDone: begin
            if (rsp_free) begin
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   assign back_color = back_oob_ff ? color_type'('0) : rd_data;

   always_ff @(posedge clock) begin
      if (query_fire) begin
         fore_ff     <= fore_index;
         back_ff     <= back_index;
         fore_oob_ff <= ({1'b0, fore_index} >= EntryLimit);
         back_oob_ff <= ({1'b0, back_index} >= EntryLimit);
      end
      if (state_ff == StRdB) begin
         fore_color_ff <= fore_oob_ff ? color_type'('0) : rd_data;
      end
      if ((state_ff == StDone) && rsp_free) begin
         rsp_data_ff <= best_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         cnt_ff       <= '0;
         issue_ctl_ff <= '0;
         pct_ff       <= PercentReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         issue_ctl_ff <= issue_ctl_in;
         if (csr_we) begin
            pct_ff <= csr_wdata;
         end
         if ((state_ff == StDone) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   pbn_palette_ram #(
      .Entries (PALETTE_ENTRIES),
      .AddrW   (AddrW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (load_fire && load_in_range),
      .wr_addr (entry_index[AddrW-1:0]),
      .wr_data (load_color),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pbn_mixer #(
      .WeightFrac (WEIGHT_FRACTION_BITS),
      .MixW       (MixW)
   ) u_mixer (
      .clock      (clock),
      .percent    (pct_ff),
      .ctl        (mix_ctl),
      .fore_color (fore_color_ff),
      .back_color (back_color),
      .mix        (mix)
   );

   pbn_scorer #(
      .WeightFrac (WEIGHT_FRACTION_BITS),
      .MixW       (MixW)
   ) u_scorer (
      .clock      (clock),
      .reset      (reset),
      .ctl        (issue_ctl_ff),
      .color      (rd_data),
      .mix        (mix),
      .done       (score_done),
      .best_index (best_index)
   );

endmodule

[bench/palette_blend_nearest_color_check.sv]
`timescale 1ns / 1ps
// Channel monitor for the palette blend block: tracks palette and opacity, predicts and compares.
module palette_blend_nearest_color_check import pbn_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [ReqDataBits-1:0] req_tdata,
   input  logic                   req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [IndexBits-1:0]   rsp_tdata,
   input  logic                   csr_we,
   input  logic [PercentBits-1:0] csr_wdata,
   output int                     mismatches,
   output int                     pending_results
);

   localparam int Entries  = PaletteEntriesDefault;
   localparam int FracBits = WeightFracDefault;

   color_type              palette [Entries];
   logic [PercentBits-1:0] opacity_percent;
   logic [IndexBits-1:0]   blend_index_q [$];

   // Score every entry against the weighted mix; ties keep the higher index.
   function automatic logic [IndexBits-1:0] nearest_blend_index(
      input logic [IndexBits-1:0] fore,
      input logic [IndexBits-1:0] back
   );
      longint                 pct, w_fore, w_back;
      longint                 mix_r, mix_g, mix_b;
      longint                 r, g, b, score, best;
      logic [IndexBits-1:0]   winner;
      pct    = (opacity_percent > MaxPercent) ? MaxPercent : opacity_percent;
      w_fore = (pct << FracBits) / PercentScale;
      w_back = (longint'(1) << FracBits) - w_fore;
      mix_r  = longint'(palette[fore].red)   * w_fore + longint'(palette[back].red)   * w_back;
      mix_g  = longint'(palette[fore].green) * w_fore + longint'(palette[back].green) * w_back;
      mix_b  = longint'(palette[fore].blue)  * w_fore + longint'(palette[back].blue)  * w_back;
      best   = 0;
      winner = '0;
      for (int i = Entries - 1; i >= 0; i--) begin
         r     = palette[i].red;
         g     = palette[i].green;
         b     = palette[i].blue;
         score = (r * r + g * g + b * b) * (longint'(1) << (FracBits - 1))
                 - r * mix_r - g * mix_g - b * mix_b;
         if (i == Entries - 1 || score < best) begin
            best   = score;
            winner = IndexBits'(i);
         end
      end
      return winner;
   endfunction

   task automatic log_failure(input string detail);
      if (mismatches < 10)
         $display("%0t: %s", $time, detail);
      mismatches++;
   endtask

   always @(posedge clock) begin
      logic [IndexBits-1:0] want;
      if (reset) begin
         opacity_percent = PercentReset;
         blend_index_q.delete();
      end else begin
         if (csr_we)
            opacity_percent = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            if (blend_index_q.size() == 0) begin
               log_failure($sformatf("unexpected result, blended_index %0d", rsp_tdata));
            end else begin
               want = blend_index_q.pop_front();
               if (rsp_tdata !== want)
                  log_failure($sformatf("blended_index expected %0d got %0d", want, rsp_tdata));
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == OpLoad)
               palette[req_tdata[7:0]] = {req_tdata[31:24], req_tdata[23:16], req_tdata[15:8]};
            else
               blend_index_q.push_back(nearest_blend_index(req_tdata[39:32], req_tdata[47:40]));
         end
      end
      pending_results = blend_index_q.size();
   end

endmodule

[bench/palette_blend_nearest_color_test.sv]
`timescale 1ns / 1ps
// Top of the palette blend bench: clock, reset, stimulus, receiver stalls and verdict.
module palette_blend_nearest_color_test;
   import pbn_pkg::*;

   localparam int SettleCycles  = PaletteEntriesDefault + 24;
   localparam int CycleLimit    = 3_000_000;
   localparam int RandomPhases  = 8;
   localparam int PhaseItems    = 146;
   localparam int SqueezeCycles = 3000;

   typedef enum {Flowing, Stalled, HalfReady, QuarterReady} ready_mode_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [ReqDataBits-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [IndexBits-1:0]   rsp_tdata;
   logic                   csr_we;
   logic [PercentBits-1:0] csr_wdata;
   int                     mismatches;
   int                     pending_results;
   int                     cycle_count;
   int                     burst_left;
   bit                     squeeze_req;
   color_type              tone_pool [4];

   palette_blend_nearest_color dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   palette_blend_nearest_color_check blend_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [ReqDataBits-1:0] pack_item(
      input logic [IndexBits-1:0] entry,
      input color_type            colour,
      input logic [IndexBits-1:0] fore,
      input logic [IndexBits-1:0] back
   );
      return {back, fore, colour.blue, colour.green, colour.red, entry};
   endfunction

   function automatic color_type random_colour();
      color_type c;
      c.red   = 8'($urandom_range(0, 255));
      c.green = 8'($urandom_range(0, 255));
      c.blue  = 8'($urandom_range(0, 255));
      return c;
   endfunction

   // Offer one item and hold it until taken; close the burst with a random gap.
   task automatic push_item(input logic op, input logic [ReqDataBits-1:0] data);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 12);
      end
   endtask

   task automatic load_entry(input logic [IndexBits-1:0] entry, input color_type colour);
      push_item(OpLoad, pack_item(entry, colour, 8'($urandom), 8'($urandom)));
   endtask

   task automatic blend_query(input logic [IndexBits-1:0] fore, input logic [IndexBits-1:0] back);
      push_item(OpQuery, pack_item(8'($urandom), random_colour(), fore, back));
   endtask

   // Drop valid, wait for every result, then let a full scan time pass.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_opacity(input logic [PercentBits-1:0] value);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("palette_blend_nearest_color test failed");
      $finish;
   end

   initial begin : receiver
      ready_mode_type mode;
      int             stretch;
      bit             squeezed;
      rsp_tready = 1'b0;
      mode       = Flowing;
      stretch    = 0;
      squeezed   = 1'b0;
      forever begin
         @(negedge clock);
         if (squeeze_req && !squeezed) begin
            // hold off long enough for the block to back up onto its input
            squeezed   = 1'b1;
            rsp_tready <= 1'b0;
            repeat (SqueezeCycles) @(negedge clock);
         end
         if (stretch == 0) begin
            mode    = ready_mode_type'($urandom_range(0, 3));
            stretch = $urandom_range(1, 40);
         end
         stretch--;
         case (mode)
            Flowing:   rsp_tready <= 1'b1;
            Stalled:   rsp_tready <= 1'b0;
            HalfReady: rsp_tready <= 1'($urandom_range(0, 1));
            default:   rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   initial begin
      color_type            colour;
      int                   style;
      logic [IndexBits-1:0] fore;
      logic [IndexBits-1:0] back;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tuser   = OpLoad;
      req_tdata   = '0;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      squeeze_req = 1'b0;
      burst_left  = 1;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // fill the whole palette first: every query scans all entries
      for (int i = 0; i < PaletteEntriesDefault; i++) begin
         colour = random_colour();
         case (i)
            0:            colour = '0;
            1:            colour = '{red: 8'hFF, default: 8'h00};
            2:            colour = '{green: 8'hFF, default: 8'h00};
            3:            colour = '{blue: 8'hFF, default: 8'h00};
            10, 20, 200:  colour = '{red: 8'd128, green: 8'd64, blue: 8'd32};
            255:          colour = '1;
            default:      ;
         endcase
         load_entry(8'(i), colour);
      end

      // directed queries at the reset opacity
      blend_query(8'd0, 8'd255);
      blend_query(8'd255, 8'd0);
      blend_query(8'd10, 8'd10);
      blend_query(8'd20, 8'd200);
      blend_query(8'd1, 8'd2);
      blend_query(8'd3, 8'd1);
      blend_query(8'd0, 8'd0);
      blend_query(8'd255, 8'd255);
      // black at both ends of the palette: the tie must go to the top entry
      load_entry(8'd255, '0);
      blend_query(8'd0, 8'd0);
      load_entry(8'd255, '1);

      write_opacity('0);
      blend_query(8'd0, 8'd255);
      blend_query(8'd1, 8'd3);
      write_opacity(MaxPercent);
      blend_query(8'd0, 8'd255);
      blend_query(8'd2, 8'd3);
      write_opacity(7'd100);
      blend_query(8'd0, 8'd255);
      write_opacity('1);
      blend_query(8'd255, 8'd0);
      blend_query(8'd10, 8'd1);
      write_opacity(7'd50);
      blend_query(8'd1, 8'd2);
      blend_query(8'd0, 8'd255);

      for (int phase = 0; phase < RandomPhases; phase++) begin
         case (phase)
            0:       write_opacity('0);
            1:       write_opacity('1);
            2:       write_opacity(MaxPercent);
            default: write_opacity(7'($urandom_range(0, 127)));
         endcase
         // palette styles: free colours, a few repeated tones, channel extremes
         style = phase % 3;
         foreach (tone_pool[k])
            tone_pool[k] = random_colour();
         if (phase == 2)
            squeeze_req = 1'b1;
         for (int n = 0; n < PhaseItems; n++) begin
            if ($urandom_range(0, 9) < 4) begin
               case (style)
                  0: colour = random_colour();
                  1: colour = tone_pool[$urandom_range(0, 3)];
                  default: begin
                     colour.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                     colour.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                     colour.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                  end
               endcase
               load_entry(8'($urandom_range(0, 255)), colour);
            end else begin
               fore = 8'($urandom_range(0, 255));
               back = ($urandom_range(0, 4) == 0) ? fore : 8'($urandom_range(0, 255));
               blend_query(fore, back);
            end
         end
      end

      settle();
      if (mismatches == 0 && pending_results == 0)
         $display("palette_blend_nearest_color test passed");
      else
         $display("palette_blend_nearest_color test failed");
      $finish;
   end

endmodule
